### src/mctb_pkg.sv
// Shared types and constants of the multi-channel timer bank.
`timescale 1ns / 1ps

package mctb_pkg;

    // Largest number of expiry results reported for one tick.
    localparam int MAX_RESULTS = 16;
    // Width of the per-tick result counter, able to hold MAX_RESULTS itself.
    localparam int CNT_W = 5;

    // Request codes carried in the request type field.
    typedef enum logic [2:0] {
        REQ_TICK   = 3'd0,
        REQ_CREATE = 3'd1,
        REQ_START  = 3'd2,
        REQ_STOP   = 3'd3,
        REQ_RESET  = 3'd4,
        REQ_CHANGE = 3'd5,
        REQ_DELETE = 3'd6
    } t_req;

    // Status codes returned with every result.
    typedef enum logic [1:0] {
        ST_OK          = 2'd0,
        ST_ZERO_PERIOD = 2'd1,
        ST_NO_FREE     = 2'd2,
        ST_NOT_USED    = 2'd3
    } t_status;

    // Sequencer states.
    typedef enum logic [2:0] {
        S_IDLE,
        S_SCAN,
        S_FIND,
        S_CMD,
        S_EMIT
    } t_state;

    // One result item, without its last marker.
    typedef struct packed {
        t_status     status;
        logic        expired;
        logic [3:0]  slot;
        logic [31:0] id;
        logic        running;
        logic [31:0] remaining;
    } t_result;

endpackage

### src/multi_channel_timer_bank.sv
// Multi-channel timer bank: timer slots, tick scan and command sequencer.
`timescale 1ns / 1ps

// A bank of NUM_TIMERS timer slots run by a 32-bit tick counter. Each request
// carries a request type (tick, create, start, stop, reset, change period,
// delete); every command returns exactly one status result, a tick returns one
// expiry result for each running slot that came due (at most 16, the last one
// marked by tlast, tuser set on expiry results) and nothing when no slot is due.
// The unused request type 7 is dropped without a result.
// The block handles one request at a time and holds tready low until its last
// result is handed to the output register. Slot periods, due ticks and ids sit
// in memories with one read and one write port, read one slot per cycle while
// the output side does not stall. A tick reads every slot, a create reads the
// slots until it finds the lowest free one, and the other commands read only
// their own slot, or none when it is not in use. A single 33-bit adder does
// all due-tick and remaining-tick arithmetic.
module multi_channel_timer_bank
    import mctb_pkg::*;
#(
    parameter int NUM_TIMERS = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    // Fields from bit 0 up: req_type[2:0], slot_index[6:3], ticks[38:7],
    // reload_mode[39].
    input  logic [39:0] i_s_axis_tdata,
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    // Fields from bit 0 up: status[1:0], result_slot[5:2], result_id[37:6],
    // is_running[38], remaining[70:39], zero fill[71].
    output logic [71:0] o_m_axis_tdata,
    // Fields: expired.
    output logic        o_m_axis_tuser,
    output logic        o_m_axis_tlast
);

    localparam int IW = (NUM_TIMERS > 1) ? $clog2(NUM_TIMERS) : 1;
    localparam logic [IW-1:0] LAST_SLOT = IW'(NUM_TIMERS - 1);

    // Control state.
    t_state           r_state, n_state;
    logic [IW-1:0]    r_ptr, n_ptr;
    logic [CNT_W-1:0] r_cnt, n_cnt;
    logic [NUM_TIMERS-1:0] r_used, n_used;
    logic [NUM_TIMERS-1:0] r_run, n_run;
    logic [NUM_TIMERS-1:0] r_auto, n_auto;
    logic [31:0]      r_now, n_now;
    logic [31:0]      r_next_id, n_next_id;
    logic             r_hold_vld, n_hold_vld;
    logic             r_out_vld, n_out_vld;

    // Latched request and result payload.
    t_req             r_req, n_req;
    logic [IW-1:0]    r_idx, n_idx;
    logic [3:0]       r_slot4, n_slot4;
    logic [31:0]      r_ticks, n_ticks;
    logic             r_mode, n_mode;
    t_result          r_hold, n_hold;
    t_result          r_out, n_out;
    logic             r_out_last, n_out_last;

    // Slot memories with registered read data.
    logic [31:0] due_mem [NUM_TIMERS];
    logic [31:0] per_mem [NUM_TIMERS];
    logic [31:0] id_mem  [NUM_TIMERS];
    logic [31:0] r_due_q, r_per_q, r_id_q;
    logic [IW-1:0] rd_addr, wr_addr;
    logic        due_we, per_we, id_we;
    logic [31:0] due_wd;

    // Shared adder.
    logic [31:0] opa, opb;
    logic        cin;
    logic [32:0] sum;
    logic [31:0] rem_add;

    // Helper signals.
    logic             in_acc;
    logic             out_free;
    logic [IW+3:0]    idx_wide;
    logic             in_range;
    logic [IW-1:0]    idx_sel;
    logic [IW+3:0]    ptr_ext;
    logic             hit;
    logic             report;
    logic             stall;
    t_req             in_req;

    assign in_acc   = i_s_axis_tvalid && o_s_axis_tready;
    assign out_free = !r_out_vld || i_m_axis_tready;
    assign in_req   = t_req'(i_s_axis_tdata[2:0]);
    assign idx_wide = {{IW{1'b0}}, i_s_axis_tdata[6:3]};
    assign in_range = idx_wide < (IW + 4)'(NUM_TIMERS);
    assign idx_sel  = idx_wide[IW-1:0];
    assign ptr_ext  = {4'b0000, r_ptr};

    // One adder serves rearm, start and the remaining-tick difference.
    assign sum     = {1'b0, opa} + {1'b0, opb} + {32'd0, cin};
    assign rem_add = (!sum[32] && (opa != 32'd0)) ? opa : 32'd0;

    // Expiry test of the slot whose memory data is on the read registers.
    assign hit    = r_used[r_ptr] && r_run[r_ptr] && !(r_due_q > r_now);
    assign report = hit && (r_cnt < CNT_W'(MAX_RESULTS));
    assign stall  = report && r_hold_vld && !out_free;

    // Sequencer: next state, slot updates and result staging.
    always_comb begin
        n_state    = r_state;
        n_ptr      = r_ptr;
        n_cnt      = r_cnt;
        n_used     = r_used;
        n_run      = r_run;
        n_auto     = r_auto;
        n_now      = r_now;
        n_next_id  = r_next_id;
        n_hold_vld = r_hold_vld;
        n_hold     = r_hold;
        n_req      = r_req;
        n_idx      = r_idx;
        n_slot4    = r_slot4;
        n_ticks    = r_ticks;
        n_mode     = r_mode;
        n_out      = r_out;
        n_out_last = r_out_last;
        n_out_vld  = r_out_vld && !i_m_axis_tready;
        o_s_axis_tready = (r_state == S_IDLE);
        rd_addr    = r_ptr;
        wr_addr    = r_ptr;
        due_we     = 1'b0;
        per_we     = 1'b0;
        id_we      = 1'b0;
        due_wd     = sum[31:0];
        opa        = r_ticks;
        opb        = r_now;
        cin        = 1'b0;

        case (r_state)
            S_IDLE: begin
                if (in_acc) begin
                    n_req   = in_req;
                    n_idx   = idx_sel;
                    n_slot4 = i_s_axis_tdata[6:3];
                    n_ticks = i_s_axis_tdata[38:7];
                    n_mode  = i_s_axis_tdata[39];
                    n_ptr   = '0;
                    n_cnt   = '0;
                    rd_addr = '0;
                    case (in_req)
                        REQ_TICK: begin
                            n_now   = r_now + 32'd1;
                            n_state = S_SCAN;
                        end
                        REQ_CREATE: begin
                            if (i_s_axis_tdata[38:7] == 32'd0) begin
                                n_hold     = '0;
                                n_hold.status = ST_ZERO_PERIOD;
                                n_hold_vld = 1'b1;
                                n_state    = S_EMIT;
                            end else begin
                                n_state = S_FIND;
                            end
                        end
                        REQ_START, REQ_STOP, REQ_RESET, REQ_CHANGE, REQ_DELETE: begin
                            if (!in_range || !r_used[idx_sel]) begin
                                n_hold        = '0;
                                n_hold.status = ST_NOT_USED;
                                n_hold.slot   = i_s_axis_tdata[6:3];
                                n_hold_vld    = 1'b1;
                                n_state       = S_EMIT;
                            end else begin
                                rd_addr = idx_sel;
                                n_state = S_CMD;
                            end
                        end
                        default: begin
                            n_state = S_IDLE;
                        end
                    endcase
                end
            end

            // Walk the slots for the lowest free one.
            S_FIND: begin
                if (!r_used[r_ptr]) begin
                    n_used[r_ptr] = 1'b1;
                    n_run[r_ptr]  = 1'b0;
                    n_auto[r_ptr] = r_mode;
                    per_we        = 1'b1;
                    id_we         = 1'b1;
                    n_next_id     = r_next_id + 32'd1;
                    n_hold        = '0;
                    n_hold.status = ST_OK;
                    n_hold.slot   = ptr_ext[3:0];
                    n_hold.id     = r_next_id;
                    n_hold_vld    = 1'b1;
                    n_state       = S_EMIT;
                end else if (r_ptr == LAST_SLOT) begin
                    n_hold        = '0;
                    n_hold.status = ST_NO_FREE;
                    n_hold_vld    = 1'b1;
                    n_state       = S_EMIT;
                end else begin
                    n_ptr = r_ptr + IW'(1);
                end
            end

            // Apply a command to an allocated slot.
            S_CMD: begin
                wr_addr       = r_idx;
                n_hold        = '0;
                n_hold.status = ST_OK;
                n_hold.slot   = r_slot4;
                n_hold.id     = r_id_q;
                n_hold_vld    = 1'b1;
                n_state       = S_EMIT;
                case (r_req)
                    REQ_START, REQ_RESET: begin
                        n_run[r_idx]     = 1'b1;
                        due_we           = 1'b1;
                        n_hold.running   = 1'b1;
                        n_hold.remaining = rem_add;
                    end
                    REQ_STOP: begin
                        n_run[r_idx] = 1'b0;
                    end
                    REQ_CHANGE: begin
                        n_hold.running = r_run[r_idx];
                        if (r_ticks == 32'd0) begin
                            // Report due minus now; carry out means no borrow.
                            opa           = r_due_q;
                            opb           = ~r_now;
                            cin           = 1'b1;
                            n_hold.status = ST_ZERO_PERIOD;
                            if (r_run[r_idx] && sum[32] && (sum[31:0] != 32'd0)) begin
                                n_hold.remaining = sum[31:0];
                            end
                        end else begin
                            per_we = 1'b1;
                            if (r_run[r_idx]) begin
                                due_we           = 1'b1;
                                n_hold.remaining = rem_add;
                            end
                        end
                    end
                    REQ_DELETE: begin
                        n_used[r_idx] = 1'b0;
                        n_run[r_idx]  = 1'b0;
                    end
                    default: begin
                        n_hold_vld = 1'b0;
                    end
                endcase
            end

            // One slot per cycle unless the output stalls; the held expiry goes out when the next one arrives.
            S_SCAN: begin
                opa = r_per_q;
                if (stall) begin
                    rd_addr = r_ptr;
                end else begin
                    rd_addr = r_ptr + IW'(1);
                    if (hit) begin
                        if (r_auto[r_ptr]) begin
                            due_we = 1'b1;
                        end else begin
                            n_run[r_ptr] = 1'b0;
                        end
                    end
                    if (report) begin
                        if (r_hold_vld) begin
                            n_out      = r_hold;
                            n_out_last = 1'b0;
                            n_out_vld  = 1'b1;
                        end
                        n_hold         = '0;
                        n_hold.status  = ST_OK;
                        n_hold.expired = 1'b1;
                        n_hold.slot    = ptr_ext[3:0];
                        n_hold.id      = r_id_q;
                        if (r_auto[r_ptr]) begin
                            n_hold.running   = 1'b1;
                            n_hold.remaining = rem_add;
                        end
                        n_hold_vld = 1'b1;
                        n_cnt      = r_cnt + CNT_W'(1);
                    end
                    if (r_ptr == LAST_SLOT) begin
                        n_state = S_EMIT;
                    end else begin
                        n_ptr = r_ptr + IW'(1);
                    end
                end
            end

            // Hand the final result of the request to the output register.
            S_EMIT: begin
                if (!r_hold_vld) begin
                    n_state = S_IDLE;
                end else if (out_free) begin
                    n_out      = r_hold;
                    n_out_last = 1'b1;
                    n_out_vld  = 1'b1;
                    n_hold_vld = 1'b0;
                    n_state    = S_IDLE;
                end
            end

            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // State register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ptr      <= '0;
            r_cnt      <= '0;
            r_used     <= '0;
            r_run      <= '0;
            r_now      <= 32'd0;
            r_next_id  <= 32'd1;
            r_hold_vld <= 1'b0;
            r_out_vld  <= 1'b0;
        end else begin
            r_ptr      <= n_ptr;
            r_cnt      <= n_cnt;
            r_used     <= n_used;
            r_run      <= n_run;
            r_now      <= n_now;
            r_next_id  <= n_next_id;
            r_hold_vld <= n_hold_vld;
            r_out_vld  <= n_out_vld;
        end
    end

    // Payload registers.
    always_ff @(posedge i_clk) begin
        r_auto     <= n_auto;
        r_req      <= n_req;
        r_idx      <= n_idx;
        r_slot4    <= n_slot4;
        r_ticks    <= n_ticks;
        r_mode     <= n_mode;
        r_hold     <= n_hold;
        r_out      <= n_out;
        r_out_last <= n_out_last;
    end

    // Slot memories: one write and one registered read per cycle.
    always_ff @(posedge i_clk) begin
        if (due_we) begin
            due_mem[wr_addr] <= due_wd;
        end
        if (per_we) begin
            per_mem[wr_addr] <= r_ticks;
        end
        if (id_we) begin
            id_mem[wr_addr] <= r_next_id;
        end
        r_due_q <= due_mem[rd_addr];
        r_per_q <= per_mem[rd_addr];
        r_id_q  <= id_mem[rd_addr];
    end

    // Output channel.
    assign o_m_axis_tvalid = r_out_vld;
    assign o_m_axis_tdata  = {1'b0, r_out.remaining, r_out.running, r_out.id,
                              r_out.slot, r_out.status};
    assign o_m_axis_tuser  = r_out.expired;
    assign o_m_axis_tlast  = r_out_last;

    // The expiry report count never passes its cap.
    a_cnt_cap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= CNT_W'(MAX_RESULTS))
        else $error("expiry report count above cap");

    // Only expiry results of a tick can be followed by more results.
    a_mid_is_expiry: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && !o_m_axis_tlast |-> o_m_axis_tuser)
        else $error("non-final result is not an expiry");

    // No staged result is left behind when a new request can be taken.
    a_idle_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_IDLE |-> !r_hold_vld)
        else $error("staged result left over in idle");

endmodule

### verif/tb_multi_channel_timer_bank.sv
// Self-checking testbench for the multi-channel timer bank with a predictor and random stalls.
`timescale 1ns / 1ps

module tb_multi_channel_timer_bank;
    import mctb_pkg::*;

    localparam int SLOTS = 16;
    // Request code that the bank ignores.
    localparam logic [2:0] REQ_UNUSED = 3'd7;

    // One request as queued for the driver, with its idle gap before it.
    typedef struct {
        logic [2:0]  kind;
        logic [3:0]  slot;
        logic [31:0] ticks;
        logic        mode;
        int unsigned gap;
    } timer_request_t;

    // One predicted result.
    typedef struct {
        t_status     status;
        logic        expired;
        logic [3:0]  slot;
        logic [31:0] id;
        logic        running;
        logic [31:0] remaining;
        logic        last;
    } timer_result_t;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        s_tvalid = 1'b0;
    logic [39:0] s_tdata = '0;
    logic        m_tready = 1'b0;
    logic        o_s_axis_tready;
    logic        o_m_axis_tvalid;
    logic [71:0] o_m_axis_tdata;
    logic        o_m_axis_tuser;
    logic        o_m_axis_tlast;

    // Requests waiting for the driver and results waiting for the output side.
    timer_request_t req_queue[$];
    timer_result_t  pending_results[$];

    // Predicted state of the timer bank.
    logic        bank_used[SLOTS];
    logic        bank_running[SLOTS];
    logic        bank_reload[SLOTS];
    logic [31:0] bank_period[SLOTS];
    logic [31:0] bank_due[SLOTS];
    logic [31:0] bank_id[SLOTS];
    logic [31:0] id_counter;
    logic [31:0] tick_now;

    // Allocation as seen while building the stimulus, to aim commands at live slots.
    logic        gen_used[SLOTS];
    logic        no_gap;

    int unsigned mismatches;
    int unsigned results_seen;

    multi_channel_timer_bank #(
        .NUM_TIMERS(SLOTS)
    ) dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (s_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (s_tdata),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (m_tready),
        .o_m_axis_tdata  (o_m_axis_tdata),
        .o_m_axis_tuser  (o_m_axis_tuser),
        .o_m_axis_tlast  (o_m_axis_tlast)
    );

    always #5 i_clk = ~i_clk;

    // Remaining ticks of a slot as the bank reports them.
    function automatic logic [31:0] ticks_left(int s);
        if (bank_running[s] && bank_due[s] > tick_now) begin
            return bank_due[s] - tick_now;
        end
        return 32'd0;
    endfunction

    function automatic void push_slot_result(t_status st, logic exp, int s);
        timer_result_t r;
        r.status    = st;
        r.expired   = exp;
        r.slot      = s[3:0];
        r.id        = bank_id[s];
        r.running   = bank_running[s];
        r.remaining = ticks_left(s);
        r.last      = 1'b1;
        pending_results.push_back(r);
    endfunction

    function automatic void push_bare_result(t_status st, logic [3:0] slot);
        timer_result_t r;
        r.status    = st;
        r.expired   = 1'b0;
        r.slot      = slot;
        r.id        = '0;
        r.running   = 1'b0;
        r.remaining = '0;
        r.last      = 1'b1;
        pending_results.push_back(r);
    endfunction

    // Works out the results of one accepted request and updates the bank state.
    function automatic void predict_request(timer_request_t rq);
        int n;
        int free_slot;
        int s;
        n = 0;
        free_slot = -1;
        s = int'(rq.slot);
        case (rq.kind)
            REQ_TICK: begin
                tick_now = tick_now + 32'd1;
                for (int k = 0; k < SLOTS; k++) begin
                    if (bank_used[k] && bank_running[k] && bank_due[k] <= tick_now) begin
                        if (bank_reload[k]) begin
                            bank_due[k] = tick_now + bank_period[k];
                        end else begin
                            bank_running[k] = 1'b0;
                            bank_due[k] = '0;
                        end
                        if (n < MAX_RESULTS) begin
                            push_slot_result(ST_OK, 1'b1, k);
                            pending_results[pending_results.size() - 1].last = 1'b0;
                            n++;
                        end
                    end
                end
                if (n > 0) begin
                    pending_results[pending_results.size() - 1].last = 1'b1;
                end
            end
            REQ_UNUSED: begin
            end
            REQ_CREATE: begin
                if (rq.ticks == 0) begin
                    push_bare_result(ST_ZERO_PERIOD, 4'd0);
                end else begin
                    for (int k = SLOTS - 1; k >= 0; k--) begin
                        if (!bank_used[k]) free_slot = k;
                    end
                    if (free_slot < 0) begin
                        push_bare_result(ST_NO_FREE, 4'd0);
                    end else begin
                        bank_used[free_slot]    = 1'b1;
                        bank_running[free_slot] = 1'b0;
                        bank_reload[free_slot]  = rq.mode;
                        bank_period[free_slot]  = rq.ticks;
                        bank_due[free_slot]     = '0;
                        bank_id[free_slot]      = id_counter;
                        id_counter = id_counter + 32'd1;
                        push_slot_result(ST_OK, 1'b0, free_slot);
                    end
                end
            end
            default: begin
                if (!bank_used[s]) begin
                    push_bare_result(ST_NOT_USED, rq.slot);
                end else if (rq.kind == REQ_START || rq.kind == REQ_RESET) begin
                    bank_running[s] = 1'b1;
                    bank_due[s] = tick_now + rq.ticks;
                    push_slot_result(ST_OK, 1'b0, s);
                end else if (rq.kind == REQ_STOP) begin
                    bank_running[s] = 1'b0;
                    bank_due[s] = '0;
                    push_slot_result(ST_OK, 1'b0, s);
                end else if (rq.kind == REQ_CHANGE) begin
                    if (rq.ticks == 0) begin
                        push_slot_result(ST_ZERO_PERIOD, 1'b0, s);
                    end else begin
                        bank_period[s] = rq.ticks;
                        if (bank_running[s]) bank_due[s] = tick_now + rq.ticks;
                        push_slot_result(ST_OK, 1'b0, s);
                    end
                end else begin
                    // Delete reports the old id, then frees the slot.
                    bank_running[s] = 1'b0;
                    bank_used[s] = 1'b0;
                    push_slot_result(ST_OK, 1'b0, s);
                end
            end
        endcase
    endfunction

    // Compares one output result with the oldest prediction.
    function automatic void check_result(logic [71:0] data, logic user, logic lastb);
        timer_result_t e;
        logic bad;
        if (pending_results.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) begin
                $display("Unexpected result: tdata=%h tuser=%b tlast=%b", data, user, lastb);
            end
            return;
        end
        e = pending_results.pop_front();
        bad = (data[1:0] != e.status) || (user != e.expired) || (data[5:2] != e.slot)
            || (data[37:6] != e.id) || (data[38] != e.running)
            || (data[70:39] != e.remaining) || (lastb != e.last);
        if (bad) begin
            mismatches++;
            if (mismatches <= 10) begin
                $display("Result mismatch: expected status=%0d expired=%b slot=%0d id=%0d run=%b rem=%0d last=%b",
                         e.status, e.expired, e.slot, e.id, e.running, e.remaining, e.last);
                $display("                 actual   status=%0d expired=%b slot=%0d id=%0d run=%b rem=%0d last=%b",
                         data[1:0], user, data[5:2], data[37:6], data[38], data[70:39], lastb);
            end
        end
    endfunction

    // Request driver: presents queued requests after their idle gap.
    int unsigned idle_count;
    timer_request_t cur_req;
    logic holding;
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            s_tvalid <= 1'b0;
            idle_count = 0;
        end else begin
            holding = s_tvalid && !o_s_axis_tready;
            if (s_tvalid && o_s_axis_tready) begin
                predict_request(cur_req);
            end
            if (!holding) begin
                if (req_queue.size() != 0 && idle_count >= req_queue[0].gap) begin
                    cur_req = req_queue.pop_front();
                    idle_count = 0;
                    s_tvalid <= 1'b1;
                    s_tdata <= {cur_req.mode, cur_req.ticks, cur_req.slot, cur_req.kind};
                end else begin
                    if (req_queue.size() != 0) idle_count++;
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // Result monitor: checks accepted results and stalls the output at random.
    int unsigned stall_left;
    logic ready_next;
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            m_tready <= 1'b0;
            stall_left = 0;
        end else begin
            if (o_m_axis_tvalid && m_tready) begin
                check_result(o_m_axis_tdata, o_m_axis_tuser, o_m_axis_tlast);
                results_seen++;
                stall_left = (results_seen % 50 >= 35) ? 0 : $urandom_range(0, 8);
                ready_next = (stall_left == 0);
            end else if (stall_left > 0) begin
                stall_left--;
                ready_next = (stall_left == 0);
            end else begin
                ready_next = 1'b1;
            end
            m_tready <= ready_next;
        end
    end

    // Queues one request and tracks slot allocation for later targeting.
    task automatic queue_request(logic [2:0] kind, logic [3:0] slot, logic [31:0] ticks,
                                 logic mode);
        timer_request_t rq;
        int free_slot;
        free_slot = -1;
        rq.kind  = kind;
        rq.slot  = slot;
        rq.ticks = ticks;
        rq.mode  = mode;
        rq.gap   = no_gap ? 0 : $urandom_range(0, 8);
        req_queue.push_back(rq);
        if (kind == REQ_CREATE && ticks != 0) begin
            for (int k = SLOTS - 1; k >= 0; k--) begin
                if (!gen_used[k]) free_slot = k;
            end
            if (free_slot >= 0) gen_used[free_slot] = 1'b1;
        end else if (kind == REQ_DELETE) begin
            gen_used[slot] = 1'b0;
        end
    endtask

    // Mostly a live slot, sometimes any slot.
    function automatic logic [3:0] pick_slot();
        int live[$];
        for (int k = 0; k < SLOTS; k++) begin
            if (gen_used[k]) live.push_back(k);
        end
        if (live.size() != 0 && $urandom_range(0, 4) != 0) begin
            return 4'(live[$urandom_range(0, live.size() - 1)]);
        end
        return 4'($urandom_range(0, SLOTS - 1));
    endfunction

    // Mostly short delays, with zero, full-range and near-wrap values mixed in.
    function automatic logic [31:0] pick_ticks();
        int unsigned r;
        r = $urandom_range(0, 19);
        if (r < 2) return 32'd0;
        if (r < 5) return $urandom;
        if (r < 7) return 32'hFFFF_FFF0 + $urandom_range(0, 15);
        return $urandom_range(1, 8);
    endfunction

    // Stimulus and end of run.
    int unsigned r;
    initial begin
        mismatches = 0;
        results_seen = 0;
        no_gap = 1'b0;
        id_counter = 32'd1;
        tick_now = '0;
        for (int k = 0; k < SLOTS; k++) begin
            bank_used[k] = 1'b0;
            bank_running[k] = 1'b0;
            bank_reload[k] = 1'b0;
            bank_period[k] = '0;
            bank_due[k] = '0;
            bank_id[k] = '0;
            gen_used[k] = 1'b0;
        end

        // Directed part: empty bank, status codes, wrap of the due tick, each command.
        queue_request(REQ_TICK, 4'd0, $urandom, 1'b0);
        queue_request(REQ_UNUSED, 4'd15, 32'hFFFF_FFFF, 1'b1);
        queue_request(REQ_CREATE, 4'd0, 32'd0, 1'b1);
        queue_request(REQ_STOP, 4'd15, 32'd0, 1'b0);
        queue_request(REQ_CREATE, 4'd0, 32'd3, 1'b1);
        queue_request(REQ_CREATE, 4'd15, 32'd5, 1'b0);
        queue_request(REQ_CREATE, 4'd0, 32'hFFFF_FFFF, 1'b1);
        queue_request(REQ_CHANGE, 4'd0, 32'd0, 1'b0);
        queue_request(REQ_START, 4'd0, 32'd1, 1'b0);
        queue_request(REQ_RESET, 4'd1, 32'd0, 1'b0);
        // A full-range delay wraps the due tick behind the counter.
        queue_request(REQ_START, 4'd2, 32'hFFFF_FFFF, 1'b0);
        queue_request(REQ_CHANGE, 4'd0, 32'd2, 1'b0);
        queue_request(REQ_TICK, 4'd15, $urandom, 1'b1);
        queue_request(REQ_TICK, 4'd0, $urandom, 1'b0);
        queue_request(REQ_TICK, 4'd7, $urandom, 1'b1);
        queue_request(REQ_STOP, 4'd0, 32'd0, 1'b0);
        queue_request(REQ_CHANGE, 4'd0, 32'd6, 1'b0);
        queue_request(REQ_DELETE, 4'd1, 32'd0, 1'b0);
        queue_request(REQ_DELETE, 4'd1, 32'd0, 1'b0);
        queue_request(REQ_START, 4'd15, 32'd4, 1'b0);
        queue_request(REQ_RESET, 4'd15, 32'd4, 1'b0);
        queue_request(REQ_DELETE, 4'd2, 32'd0, 1'b0);

        // Fill the bank past its end, start every slot close together, tick.
        for (int k = 0; k < SLOTS + 1; k++) begin
            queue_request(REQ_CREATE, 4'($urandom), $urandom_range(1, 6),
                          1'($urandom_range(0, 1)));
        end
        for (int k = 0; k < SLOTS; k++) begin
            queue_request(REQ_START, 4'(k), $urandom_range(0, 2), 1'b0);
        end
        no_gap = 1'b1;
        for (int k = 0; k < 6; k++) begin
            queue_request(REQ_TICK, 4'($urandom), $urandom, 1'($urandom_range(0, 1)));
        end
        no_gap = 1'b0;

        // Random mix, ticks weighted to keep slots expiring.
        for (int i = 0; i < 100; i++) begin
            no_gap = (i % 40) >= 30;
            r = $urandom_range(0, 99);
            if (r < 35) begin
                queue_request(REQ_TICK, 4'($urandom), $urandom, 1'($urandom_range(0, 1)));
            end else if (r < 50) begin
                queue_request(REQ_CREATE, 4'($urandom), pick_ticks(),
                              1'($urandom_range(0, 1)));
            end else if (r < 62) begin
                queue_request(REQ_START, pick_slot(), pick_ticks(), 1'($urandom_range(0, 1)));
            end else if (r < 70) begin
                queue_request(REQ_RESET, pick_slot(), pick_ticks(), 1'($urandom_range(0, 1)));
            end else if (r < 77) begin
                queue_request(REQ_STOP, pick_slot(), $urandom, 1'($urandom_range(0, 1)));
            end else if (r < 87) begin
                queue_request(REQ_CHANGE, pick_slot(), pick_ticks(), 1'($urandom_range(0, 1)));
            end else if (r < 95) begin
                queue_request(REQ_DELETE, pick_slot(), $urandom, 1'($urandom_range(0, 1)));
            end else if (r < 98) begin
                queue_request(REQ_UNUSED, 4'($urandom), $urandom, 1'($urandom_range(0, 1)));
            end else begin
                queue_request(3'($urandom_range(0, 7)), 4'($urandom), $urandom,
                              1'($urandom_range(0, 1)));
            end
        end

        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Finish only once the last request is taken and all its results are checked.
        wait (req_queue.size() == 0);
        do begin
            @(negedge i_clk);
        end while (s_tvalid || pending_results.size() != 0);
        repeat (40) @(posedge i_clk);
        if (mismatches == 0) begin
            $display("multi_channel_timer_bank test passed");
        end else begin
            $display("multi_channel_timer_bank test failed");
        end
        $finish;
    end

    // Watchdog for a hung handshake.
    initial begin
        #5_000_000;
        $display("multi_channel_timer_bank test failed");
        $finish;
    end

endmodule
